// File: hw/rtl/rcr_pkg.sv
// Shared types and constants for the rectangle canvas rasterizer.
`default_nettype none

package rcr_pkg;

  // Fixed-point format of coordinates and sizes: signed Q15.8.
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned COORD_W   = 24;

  // Width of the signed bound compares; covers a corner plus a size and any cell position.
  localparam int unsigned CMP_W = 27;

  // One whole unit in Q15.8.
  localparam logic signed [CMP_W-1:0] ONE_UNIT = CMP_W'(256);

  // Shape type bytes.
  localparam logic [7:0] TYPE_OUTLINE = 8'd114;
  localparam logic [7:0] TYPE_FILLED  = 8'd82;

  // Configuration register indexes and the width of the write port.
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BACKGROUND    = 2'd2;

  // Command codes.
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_READ
  } state_t;

  // One command transaction.
  typedef struct packed {
    action_t                   action;
    logic [7:0]                shape_type;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic signed [COORD_W-1:0] rect_width;
    logic signed [COORD_W-1:0] rect_height;
    logic [7:0]                paint_char;
    logic [7:0]                read_row;
    logic [7:0]                read_col;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] cell_value;
    logic       status;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/rcr_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none

module rcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable; the read port samples the same address every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/rectangle_canvas_rasterizer.sv
// Top level of the rectangle canvas rasterizer: command decode, canvas sweep and read-back.
`default_nettype none

// The canvas lives in one single-port RAM of at least MAX_SIDE x MAX_SIDE
// bytes and is undefined after reset until the first clear; there is no
// clearing pass. A clear visits every active cell once, a draw first sets up
// its bounds and then runs the same sweep over the active cells, and a read makes
// one registered access to the RAM; the result strobe comes in the cycle after
// the work ends. A rejected draw and the unused action finish at once: their
// result comes in the next cycle and busy stays low. The single RAM write
// port, one cell per cycle, sets the clear and draw times. Results are shown
// for exactly one cycle with done high; the receiver cannot stall them.
// Configuration may be written only while busy is low and no result is
// pending.
module rectangle_canvas_rasterizer #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire rcr_pkg::cmd_t                      cmd,
  output logic                                    done,
  output rcr_pkg::result_t                        result,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [rcr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Cell index width, active side width and RAM address width.
  localparam int unsigned CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned AW    = 2 * CW;
  localparam int unsigned DEPTH = 1 << AW;

  rcr_pkg::state_t state;
  rcr_pkg::state_t state_next;

  logic [8:0] canvas_width;
  logic [8:0] canvas_height;
  logic [7:0] background_char;

  logic [SW-1:0] w_eff;
  logic [SW-1:0] h_eff;

  logic [CW-1:0] row;
  logic [CW-1:0] col;
  logic          op_clear;
  logic          filled;
  logic [7:0]    color;
  logic          read_ok;

  logic signed [rcr_pkg::CMP_W-1:0] x_lo;
  logic signed [rcr_pkg::CMP_W-1:0] y_lo;
  logic signed [rcr_pkg::CMP_W-1:0] x_hi;
  logic signed [rcr_pkg::CMP_W-1:0] y_hi;
  logic signed [rcr_pkg::CMP_W-1:0] x_lo_in;
  logic signed [rcr_pkg::CMP_W-1:0] y_lo_in;
  logic signed [rcr_pkg::CMP_W-1:0] rect_w;
  logic signed [rcr_pkg::CMP_W-1:0] rect_h;

  logic signed [rcr_pkg::CMP_W-1:0] px;
  logic signed [rcr_pkg::CMP_W-1:0] py;
  logic signed [rcr_pkg::CMP_W-1:0] px1;
  logic signed [rcr_pkg::CMP_W-1:0] py1;

  logic accept;
  logic draw_bad;
  logic col_last;
  logic row_last;
  logic in_rect;
  logic border;
  logic paint;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  rcr_pkg::result_t result_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= 9'd1;
      canvas_height   <= 9'd1;
      background_char <= 8'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        rcr_pkg::CFG_CANVAS_WIDTH:  canvas_width    <= cfg_data;
        rcr_pkg::CFG_CANVAS_HEIGHT: canvas_height   <= cfg_data;
        rcr_pkg::CFG_BACKGROUND:    background_char <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Active size, with zero taken as one and values above MAX_SIDE clamped.
  always_comb begin
    if (canvas_width == 9'd0) begin
      w_eff = SW'(1);
    end else if (32'(canvas_width) > MAX_SIDE) begin
      w_eff = SW'(MAX_SIDE);
    end else begin
      w_eff = SW'(canvas_width);
    end
    if (canvas_height == 9'd0) begin
      h_eff = SW'(1);
    end else if (32'(canvas_height) > MAX_SIDE) begin
      h_eff = SW'(MAX_SIDE);
    end else begin
      h_eff = SW'(canvas_height);
    end
  end

  // Command decode.
  assign busy     = (state != rcr_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign draw_bad = (cmd.rect_width <= 24'sd0) || (cmd.rect_height <= 24'sd0) ||
                    ((cmd.shape_type != rcr_pkg::TYPE_OUTLINE) &&
                     (cmd.shape_type != rcr_pkg::TYPE_FILLED));

  // Sweep position in Q15.8, and one unit further along.
  assign px  = rcr_pkg::CMP_W'({col, {rcr_pkg::FRAC_BITS{1'b0}}});
  assign py  = rcr_pkg::CMP_W'({row, {rcr_pkg::FRAC_BITS{1'b0}}});
  assign px1 = rcr_pkg::CMP_W'({{1'b0, col} + (CW + 1)'(1), {rcr_pkg::FRAC_BITS{1'b0}}});
  assign py1 = rcr_pkg::CMP_W'({{1'b0, row} + (CW + 1)'(1), {rcr_pkg::FRAC_BITS{1'b0}}});

  assign col_last = ((SW'(col) + SW'(1)) == w_eff);
  assign row_last = ((SW'(row) + SW'(1)) == h_eff);

  // Closed bounds; a cell is on the border when under one unit from an edge.
  assign in_rect = (px >= x_lo) && (px <= x_hi) && (py >= y_lo) && (py <= y_hi);
  assign border  = (px < x_lo_in) || (px1 > x_hi) || (py < y_lo_in) || (py1 > y_hi);
  assign paint   = in_rect && (filled || border);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rcr_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd.action)
            rcr_pkg::ACT_CLEAR: state_next = rcr_pkg::ST_SWEEP;
            rcr_pkg::ACT_DRAW:  state_next = draw_bad ? rcr_pkg::ST_IDLE : rcr_pkg::ST_SETUP;
            rcr_pkg::ACT_READ:  state_next = rcr_pkg::ST_READ;
            default:            state_next = rcr_pkg::ST_IDLE;
          endcase
        end
      end
      rcr_pkg::ST_SETUP: state_next = rcr_pkg::ST_SWEEP;
      rcr_pkg::ST_SWEEP: begin
        if (col_last && row_last) begin
          state_next = rcr_pkg::ST_IDLE;
        end
      end
      rcr_pkg::ST_READ: state_next = rcr_pkg::ST_IDLE;
      default:          state_next = rcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command capture, bound setup and sweep counters.
  always_ff @(posedge clk) begin
    if (state == rcr_pkg::ST_IDLE) begin
      row      <= '0;
      col      <= '0;
      op_clear <= (cmd.action == rcr_pkg::ACT_CLEAR);
      filled   <= (cmd.shape_type == rcr_pkg::TYPE_FILLED);
      color    <= cmd.paint_char;
      x_lo     <= rcr_pkg::CMP_W'(cmd.x_pos);
      y_lo     <= rcr_pkg::CMP_W'(cmd.y_pos);
      rect_w   <= rcr_pkg::CMP_W'(cmd.rect_width);
      rect_h   <= rcr_pkg::CMP_W'(cmd.rect_height);
      read_ok  <= (32'(cmd.read_row) < 32'(h_eff)) && (32'(cmd.read_col) < 32'(w_eff));
    end else if (state == rcr_pkg::ST_SETUP) begin
      x_hi    <= x_lo + rect_w;
      y_hi    <= y_lo + rect_h;
      x_lo_in <= x_lo + rcr_pkg::ONE_UNIT;
      y_lo_in <= y_lo + rcr_pkg::ONE_UNIT;
    end else if (state == rcr_pkg::ST_SWEEP) begin
      if (col_last) begin
        col <= '0;
        row <= row + CW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Canvas port: the sweep writes, an idle cycle presents the read address.
  // A read is accepted only after the sweep has left, so no forwarding is needed.
  assign ram_we    = (state == rcr_pkg::ST_SWEEP) && (op_clear || paint);
  assign ram_wdata = op_clear ? background_char : color;
  assign ram_addr  = (state == rcr_pkg::ST_SWEEP) ? {row, col} :
                     {CW'(cmd.read_row), CW'(cmd.read_col)};

  rcr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && (cmd.action == rcr_pkg::ACT_NONE)) ||
              (accept && (cmd.action == rcr_pkg::ACT_DRAW) && draw_bad) ||
              ((state == rcr_pkg::ST_SWEEP) && col_last && row_last) ||
              (state == rcr_pkg::ST_READ);
    end
  end

  // Result payload.
  always_comb begin
    result_next = '0;
    if (state == rcr_pkg::ST_READ) begin
      result_next.cell_value = read_ok ? ram_rdata : 8'd0;
    end else if (accept && (cmd.action == rcr_pkg::ACT_DRAW) && draw_bad) begin
      result_next.status = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/rcr_checker.sv
// Port-level checks for the rectangle canvas rasterizer, bound to the top level.
`default_nettype none

module rcr_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic                           busy,
  input wire rcr_pkg::cmd_t                  cmd,
  input wire logic                           done,
  input wire rcr_pkg::result_t               result,
  input wire logic                           cfg_we,
  input wire logic [1:0]                     cfg_index,
  input wire logic [rcr_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic accept;
  logic cfg_seen;

  assign accept   = start && !busy;
  assign cfg_seen = cfg_we && (cfg_index != rcr_pkg::CFG_BACKGROUND || cfg_data[8] == 1'b0 ||
                               cfg_data[8] == 1'b1);

  // A clear transaction always raises busy in the next cycle.
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.action == rcr_pkg::ACT_CLEAR) |=> busy)
    else $error("clear transaction did not raise busy");

  // A draw with a non-positive size is rejected in the next cycle.
  a_bad_draw: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.action == rcr_pkg::ACT_DRAW) &&
    ((cmd.rect_width <= 24'sd0) || (cmd.rect_height <= 24'sd0))
    |=> done && result.status && !busy)
    else $error("rejected draw not reported in the next cycle");

  // A read transaction answers after its RAM access and the read state, with status clear.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.action == rcr_pkg::ACT_READ) |-> ##2 done && !result.status)
    else $error("read result missing or flagged");

  // A rejection never carries a cell value.
  a_status_value: assert property (@(posedge clk) disable iff (rst)
    done && result.status |-> result.cell_value == 8'd0)
    else $error("rejected transaction carries a cell value");

  // The unused action answers at once with an all-zero result; the check covers
  // only accepts without a config write.
  a_no_op: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.action == rcr_pkg::ACT_NONE) && !cfg_seen
    |=> done && (result.cell_value == 8'd0) && !result.status)
    else $error("unused action gave a wrong result");

endmodule

bind rectangle_canvas_rasterizer rcr_checker u_rcr_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the rectangle canvas rasterizer with a canvas predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SIDE = 256;
  localparam longint Q_ONE = 256;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  // A queued command and whether the driver must wait for all results before sending it.
  typedef struct {
    rcr_pkg::cmd_t cmd;
    bit            hold;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  rcr_pkg::cmd_t cmd = '0;
  logic done;
  rcr_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = rcr_pkg::CFG_CANVAS_WIDTH;
  logic [rcr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the registers and the canvas.
  logic [8:0] cfg_cols = 9'd1;
  logic [8:0] cfg_rows = 9'd1;
  logic [7:0] bg_char = 8'd32;
  logic [7:0] shadow_canvas [0:SIDE*SIDE-1];

  stim_t cmd_backlog[$];
  rcr_pkg::result_t expected_results[$];
  logic results_drained = 1'b1;
  int unsigned gap_pct = 0;
  int unsigned idle_left = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  rectangle_canvas_rasterizer #(
    .MAX_SIDE(SIDE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Register values outside 1..SIDE are pinned to the nearest legal size.
  function automatic int unsigned span_of(logic [8:0] v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return 32'(v);
  endfunction

  // Applies one command to the shadow canvas and returns the result it should produce.
  function automatic rcr_pkg::result_t rasterize_command(rcr_pkg::cmd_t c);
    rcr_pkg::result_t outcome;
    int unsigned cols, rows, r, k;
    longint x0, y0, wd, ht, px, py;
    bit near_rim;
    outcome = '0;
    cols = span_of(cfg_cols);
    rows = span_of(cfg_rows);
    case (c.action)
      rcr_pkg::ACT_CLEAR: begin
        for (r = 0; r < rows; r++)
          for (k = 0; k < cols; k++)
            shadow_canvas[r*SIDE + k] = bg_char;
      end
      rcr_pkg::ACT_DRAW: begin
        x0 = longint'($signed(c.x_pos));
        y0 = longint'($signed(c.y_pos));
        wd = longint'($signed(c.rect_width));
        ht = longint'($signed(c.rect_height));
        if (wd <= 0 || ht <= 0 ||
            (c.shape_type != rcr_pkg::TYPE_OUTLINE &&
             c.shape_type != rcr_pkg::TYPE_FILLED)) begin
          outcome.status = 1'b1;
        end else begin
          for (r = 0; r < rows; r++) begin
            for (k = 0; k < cols; k++) begin
              px = longint'(k) * Q_ONE;
              py = longint'(r) * Q_ONE;
              if (px >= x0 && px <= x0 + wd && py >= y0 && py <= y0 + ht) begin
                // Within one unit of any edge counts as border.
                near_rim = (px - x0 < Q_ONE) || (x0 + wd - px < Q_ONE) ||
                           (py - y0 < Q_ONE) || (y0 + ht - py < Q_ONE);
                if (near_rim || c.shape_type == rcr_pkg::TYPE_FILLED)
                  shadow_canvas[r*SIDE + k] = c.paint_char;
              end
            end
          end
        end
      end
      rcr_pkg::ACT_READ: begin
        if (c.read_row < rows && c.read_col < cols)
          outcome.cell_value = shadow_canvas[int'(c.read_row)*SIDE + int'(c.read_col)];
      end
      default: begin
      end
    endcase
    return outcome;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 100)
      $display("ERROR cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
  endtask

  // Driver: presents queued commands, with random idle bursts between them.
  always @(posedge clk) begin : drive_proc
    logic next_start;
    rcr_pkg::cmd_t next_cmd;
    stim_t nxt;
    next_start = start;
    next_cmd = cmd;
    if (rst) begin
      next_start = 1'b0;
      next_cmd = '0;
      idle_left = 0;
    end else begin
      if (start && !busy) next_start = 1'b0;
      if (!next_start) begin
        if (idle_left != 0) begin
          idle_left--;
        end else if (cmd_backlog.size() != 0 &&
                     (!cmd_backlog[0].hold || (!start && results_drained))) begin
          if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            idle_left = $urandom_range(1, 15);
          end else begin
            nxt = cmd_backlog.pop_front();
            next_cmd = nxt.cmd;
            next_start = 1'b1;
          end
        end
      end
    end
    start <= next_start;
    cmd <= next_cmd;
  end

  // Monitor: checks each result against the oldest prediction, then predicts new transactions.
  always @(posedge clk) begin : check_proc
    rcr_pkg::result_t want;
    if (rst) begin
      expected_results.delete();
      results_drained <= 1'b1;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, cell_value", result.cell_value, 0);
        end else begin
          want = expected_results.pop_front();
          if (result.cell_value !== want.cell_value)
            report_mismatch("cell_value", result.cell_value, want.cell_value);
          if (result.status !== want.status)
            report_mismatch("status", result.status, want.status);
        end
      end
      if (start && !busy) expected_results.push_back(rasterize_command(cmd));
      results_drained <= (expected_results.size() == 0);
    end
  end

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rectangle_canvas_rasterizer: mismatch");
      $finish;
    end
  end

  function automatic rcr_pkg::cmd_t random_fields();
    rcr_pkg::cmd_t c;
    c.action = rcr_pkg::action_t'($urandom_range(3));
    c.shape_type = 8'($urandom);
    c.x_pos = 24'($urandom);
    c.y_pos = 24'($urandom);
    c.rect_width = 24'($urandom);
    c.rect_height = 24'($urandom);
    c.paint_char = 8'($urandom);
    c.read_row = 8'($urandom);
    c.read_col = 8'($urandom);
    return c;
  endfunction

  function automatic rcr_pkg::cmd_t clear_cmd();
    rcr_pkg::cmd_t c;
    c = random_fields();
    c.action = rcr_pkg::ACT_CLEAR;
    return c;
  endfunction

  function automatic rcr_pkg::cmd_t draw_cmd(logic [7:0] kind, int x, int y, int w, int h,
                                             logic [7:0] color);
    rcr_pkg::cmd_t c;
    c = random_fields();
    c.action = rcr_pkg::ACT_DRAW;
    c.shape_type = kind;
    c.x_pos = 24'(x);
    c.y_pos = 24'(y);
    c.rect_width = 24'(w);
    c.rect_height = 24'(h);
    c.paint_char = color;
    return c;
  endfunction

  function automatic rcr_pkg::cmd_t read_cmd(int row, int col);
    rcr_pkg::cmd_t c;
    c = random_fields();
    c.action = rcr_pkg::ACT_READ;
    c.read_row = 8'(row);
    c.read_col = 8'(col);
    return c;
  endfunction

  function automatic rcr_pkg::cmd_t nop_cmd();
    rcr_pkg::cmd_t c;
    c = random_fields();
    c.action = rcr_pkg::ACT_NONE;
    return c;
  endfunction

  task automatic queue_cmd(rcr_pkg::cmd_t c, bit hold = 1'b0);
    stim_t s;
    s.cmd = c;
    s.hold = hold;
    cmd_backlog.push_back(s);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      rcr_pkg::CFG_CANVAS_WIDTH: cfg_cols = value;
      rcr_pkg::CFG_CANVAS_HEIGHT: cfg_rows = value;
      default: bg_char = value[7:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Writes all three registers, then steps off the clock edge before queuing commands.
  task automatic set_canvas(logic [8:0] w, logic [8:0] h, logic [7:0] bg);
    write_reg(rcr_pkg::CFG_CANVAS_WIDTH, w);
    write_reg(rcr_pkg::CFG_CANVAS_HEIGHT, h);
    write_reg(rcr_pkg::CFG_BACKGROUND, {1'b0, bg});
    @(negedge clk);
  endtask

  // Waits until every command has been sent and answered, plus a short settle time.
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || start || !results_drained) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random traffic for the current canvas size; each batch opens with a clear.
  task automatic random_phase(int count);
    int unsigned w, h, pick, sub;
    rcr_pkg::cmd_t c;
    w = span_of(cfg_cols);
    h = span_of(cfg_rows);
    queue_cmd(clear_cmd());
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      c = random_fields();
      if (pick < 8) begin
        c.action = rcr_pkg::ACT_CLEAR;
      end else if (pick < 50) begin
        // Well-formed rectangle around the active area.
        c.action = rcr_pkg::ACT_DRAW;
        c.shape_type = $urandom_range(1) ? rcr_pkg::TYPE_OUTLINE : rcr_pkg::TYPE_FILLED;
        c.x_pos = 24'(int'($urandom_range((w + 5) * 256)) - 768);
        c.y_pos = 24'(int'($urandom_range((h + 5) * 256)) - 768);
        c.rect_width = 24'($urandom_range(1, (w + 3) * 256));
        c.rect_height = 24'($urandom_range(1, (h + 3) * 256));
      end else if (pick < 60) begin
        // Broken draws: raw fields, a non-positive size, or a bad type byte.
        c.action = rcr_pkg::ACT_DRAW;
        sub = $urandom_range(2);
        if (sub == 1) begin
          c.shape_type = $urandom_range(1) ? rcr_pkg::TYPE_OUTLINE : rcr_pkg::TYPE_FILLED;
          if ($urandom_range(1)) c.rect_width = 24'(-int'($urandom_range(2000)));
          else c.rect_height = 24'(-int'($urandom_range(2000)));
        end else if (sub == 2) begin
          if (c.shape_type == rcr_pkg::TYPE_OUTLINE || c.shape_type == rcr_pkg::TYPE_FILLED)
            c.shape_type = 8'd0;
          c.rect_width = 24'($urandom_range(1, (w + 3) * 256));
          c.rect_height = 24'($urandom_range(1, (h + 3) * 256));
        end
      end else if (pick < 94) begin
        c.action = rcr_pkg::ACT_READ;
        if ($urandom_range(9) != 0) begin
          c.read_row = 8'($urandom_range(h - 1));
          c.read_col = 8'($urandom_range(w - 1));
        end
      end else begin
        c.action = rcr_pkg::ACT_NONE;
      end
      queue_cmd(c, $urandom_range(99) < 3);
    end
  endtask

  // Stimulus sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed checks on a small canvas.
    set_canvas(9'd16, 9'd12, 8'h2E);
    gap_pct = 30;
    queue_cmd(clear_cmd());
    queue_cmd(read_cmd(0, 0));
    queue_cmd(read_cmd(11, 15));
    queue_cmd(read_cmd(12, 0));
    queue_cmd(read_cmd(0, 16));
    queue_cmd(read_cmd(255, 255));
    queue_cmd(draw_cmd(rcr_pkg::TYPE_FILLED, 2*256, 1*256, 5*256, 3*256, 8'h23));
    queue_cmd(draw_cmd(rcr_pkg::TYPE_OUTLINE, 128, 64, 10*256 + 128, 6*256, 8'h2A), 1'b1);
    queue_cmd(draw_cmd(rcr_pkg::TYPE_OUTLINE, 8*256, 8*256, 1, 1, 8'hFF));
    queue_cmd(draw_cmd(rcr_pkg::TYPE_FILLED, 256, 256, 0, 256, 8'h41));
    queue_cmd(draw_cmd(rcr_pkg::TYPE_OUTLINE, 256, 256, 256, 0, 8'h42));
    queue_cmd(draw_cmd(rcr_pkg::TYPE_FILLED, 0, 0, -1, 4*256, 8'h43));
    queue_cmd(draw_cmd(rcr_pkg::TYPE_OUTLINE, 0, 0, 4*256, -8388608, 8'h44));
    queue_cmd(draw_cmd(8'd0, 0, 0, 4*256, 4*256, 8'h45));
    queue_cmd(draw_cmd(8'hFF, 0, 0, 4*256, 4*256, 8'h46));
    queue_cmd(nop_cmd());
    queue_cmd(draw_cmd(rcr_pkg::TYPE_OUTLINE, 8388607, 8388607, 8388607, 8388607, 8'h47));
    queue_cmd(draw_cmd(rcr_pkg::TYPE_FILLED, -8388608, -8388608, 8388607, 8388607, 8'h48));
    queue_cmd(read_cmd(1, 2));
    queue_cmd(read_cmd(2, 4));
    queue_cmd(read_cmd(6, 10));
    queue_cmd(read_cmd(8, 8));
    queue_cmd(read_cmd(3, 5));
    queue_cmd(draw_cmd(rcr_pkg::TYPE_FILLED, -1024, -1024, 8388607, 8388607, 8'h00));
    queue_cmd(read_cmd(5, 5));
    wait_idle();

    // Out-of-range register values: one column, all rows.
    set_canvas(9'd0, 9'd511, 8'h00);
    gap_pct = 50;
    random_phase(12);
    wait_idle();

    // All columns, one row.
    set_canvas(9'd300, 9'd0, 8'hA5);
    gap_pct = 10;
    random_phase(12);
    wait_idle();

    // Full canvas: only a few sweeps, since each one visits every cell.
    set_canvas(9'd256, 9'd256, 8'hFF);
    gap_pct = 20;
    queue_cmd(clear_cmd());
    queue_cmd(draw_cmd(rcr_pkg::TYPE_OUTLINE, 10*256 + 64, 20*256, 100*256, 50*256,
                       8'($urandom)));
    queue_cmd(draw_cmd(rcr_pkg::TYPE_FILLED, -5*256, 200*256, 300*256, 80*256,
                       8'($urandom)));
    queue_cmd(read_cmd(0, 0));
    queue_cmd(read_cmd(20, 10));
    queue_cmd(read_cmd(20, 50));
    queue_cmd(read_cmd(70, 110));
    queue_cmd(read_cmd(60, 60));
    queue_cmd(read_cmd(21, 11));
    queue_cmd(read_cmd(199, 100));
    queue_cmd(read_cmd(200, 0));
    queue_cmd(read_cmd(255, 255));
    queue_cmd(draw_cmd(rcr_pkg::TYPE_FILLED, 0, 0, 256, -256, 8'h11));
    queue_cmd(nop_cmd());
    wait_idle();

    // Random small canvases; the last batch runs without idle gaps.
    for (int p = 0; p < 4; p++) begin
      set_canvas(9'($urandom_range(1, 24)), 9'($urandom_range(1, 24)), 8'($urandom));
      gap_pct = (p == 3) ? 0 : $urandom_range(10, 60);
      random_phase(10);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("rectangle_canvas_rasterizer: match");
    end else begin
      $display("rectangle_canvas_rasterizer: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rcr_pkg.sv
hw/rtl/rcr_ram.sv
hw/rtl/rectangle_canvas_rasterizer.sv
hw/rtl/rcr_checker.sv
tb/sv/tb_top.sv
